/* rtl/core/mfq_pkg.sv */
// Shared types, constants and helper functions for the multilevel feedback
// queue scheduler. No dependencies; every other file imports this package.
package mfq_pkg;

	localparam int MAX_QUEUES = 8;
	localparam int MAX_PROCS  = 16;

	localparam int LVL_W   = $clog2(MAX_QUEUES);
	localparam int POS_W   = $clog2(MAX_PROCS);
	localparam int ADDR_W  = LVL_W + POS_W;
	localparam int DEPTH   = MAX_QUEUES * MAX_PROCS;
	localparam int CNT_W   = $clog2(MAX_PROCS + 1);
	localparam int ID_W    = 5;
	localparam int LEVEL_W = 4;
	localparam int NQ_W    = 4;
	localparam int NP_W    = 5;
	localparam int BP_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_QUEUES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST_PERIOD = 2'd2;

	typedef enum logic [1:0] {
		EV_RAN   = 2'd0,
		EV_EXIT  = 2'd1,
		EV_BOOST = 2'd2,
		EV_IDLE  = 2'd3
	} ev_t;

	typedef struct packed {
		ev_t                event_res;
		logic               cmd_echo;
		logic [ID_W-1:0]    proc_id;
		logic [LEVEL_W-1:0] level;
		logic [ID_W-1:0]    next_proc;
		logic               all_done;
		logic               last_of_run;
	} res_t;

	// Pointer update commands from the sequencer to the pointer file.
	typedef struct packed {
		logic             clr_all;
		logic             pop_en;
		logic [LVL_W-1:0] pop_q;
		logic             push_en;
		logic [LVL_W-1:0] push_q;
	} ptr_op_t;

	// Pointer file status seen by the sequencer.
	typedef struct packed {
		logic             busy_vld;
		logic [LVL_W-1:0] busy_q;
		logic [POS_W-1:0] sel_head;
		logic [POS_W-1:0] sel_tail;
		logic [CNT_W-1:0] sel_count;
		logic [POS_W-1:0] push_tail;
		logic             push_ok;
	} ptr_stat_t;

	// Number of levels in use: zero acts as one, large values saturate.
	function automatic logic [NQ_W-1:0] levels_used(input logic [NQ_W-1:0] nq);
		logic [NQ_W-1:0] r;
		if (nq == '0) begin
			r = NQ_W'(1);
		end else if (nq > NQ_W'(MAX_QUEUES)) begin
			r = NQ_W'(MAX_QUEUES);
		end else begin
			r = nq;
		end
		return r;
	endfunction

	// Number of processes loaded on start, saturated at the table size.
	function automatic logic [NP_W-1:0] procs_used(input logic [NP_W-1:0] np);
		logic [NP_W-1:0] r;
		if (np > NP_W'(MAX_PROCS)) begin
			r = NP_W'(MAX_PROCS);
		end else begin
			r = np;
		end
		return r;
	endfunction

endpackage

/* rtl/core/mfq_ifs.sv */
// Valid/ready channel interfaces of the scheduler: slice requests, result
// reports and configuration writes. Depends on mfq_pkg for field widths.
interface mfq_slice_if;
	logic valid;
	logic ready;
	logic kind;
	logic demote_cmd;
	logic last_cmd;
	modport source (output valid, kind, demote_cmd, last_cmd, input ready);
	modport sink (input valid, kind, demote_cmd, last_cmd, output ready);
endinterface

interface mfq_report_if import mfq_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         event_res;
	logic               cmd_echo;
	logic [ID_W-1:0]    proc_id;
	logic [LEVEL_W-1:0] level;
	logic [ID_W-1:0]    next_proc;
	logic               all_done;
	logic               last_of_run;
	modport source (output valid, event_res, cmd_echo, proc_id, level, next_proc,
		all_done, last_of_run, input ready);
	modport sink (input valid, event_res, cmd_echo, proc_id, level, next_proc,
		all_done, last_of_run, output ready);
endinterface

interface mfq_cfg_if import mfq_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/mfq_ram.sv */
// Queue entry store: one write port, one read port, registered read data.
// Depends on mfq_pkg for depth and widths.
module mfq_ram import mfq_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ID_W-1:0]   wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [ID_W-1:0]   rd_data
);

	logic [ID_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/mfq_ptrs.sv */
// Per-level head, tail and count registers, plus the search for the highest
// non-empty level in use. Depends on mfq_pkg.
module mfq_ptrs import mfq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ptr_op_t          op,
	input  logic [LVL_W-1:0] sel_q,
	input  logic [NQ_W-1:0]  nq,
	output ptr_stat_t        st
);

	logic [POS_W-1:0] head_q  [MAX_QUEUES];
	logic [POS_W-1:0] tail_q  [MAX_QUEUES];
	logic [CNT_W-1:0] count_q [MAX_QUEUES];
	logic             push_do;

	always_comb begin
		st = '0;
		st.sel_head  = head_q[sel_q];
		st.sel_tail  = tail_q[sel_q];
		st.sel_count = count_q[sel_q];
		st.push_tail = tail_q[op.push_q];
		// A pop from the same level in the same cycle frees a slot first.
		st.push_ok = (count_q[op.push_q] != CNT_W'(MAX_PROCS)) ||
			(op.pop_en && (op.pop_q == op.push_q));
		// Ascending scan, so the highest non-empty level wins.
		for (int i = 0; i < MAX_QUEUES; i++) begin
			if ((NQ_W'(i) < nq) && (count_q[i] != '0)) begin
				st.busy_vld = 1'b1;
				st.busy_q   = LVL_W'(i);
			end
		end
	end

	assign push_do = op.push_en && st.push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (op.clr_all) begin
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < MAX_QUEUES; i++) begin
				if (op.pop_en && (op.pop_q == LVL_W'(i))) begin
					head_q[i] <= head_q[i] + POS_W'(1);
				end
				if (push_do && (op.push_q == LVL_W'(i))) begin
					tail_q[i] <= tail_q[i] + POS_W'(1);
				end
				count_q[i] <= count_q[i]
					+ CNT_W'(push_do && (op.push_q == LVL_W'(i)))
					- CNT_W'(op.pop_en && (op.pop_q == LVL_W'(i)));
			end
		end
	end

endmodule

/* rtl/core/mfq_outreg.sv */
// Output register of the report channel: holds one result until the sink
// takes it. Depends on mfq_pkg and mfq_report_if.
module mfq_outreg import mfq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  res_t  res,
	output logic  free,
	mfq_report_if.source report
);

	assign free = !report.valid || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report.valid <= 1'b0;
		end else if (load) begin
			report.valid <= 1'b1;
		end else if (report.ready) begin
			report.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			report.event_res   <= res.event_res;
			report.cmd_echo    <= res.cmd_echo;
			report.proc_id     <= res.proc_id;
			report.level       <= res.level;
			report.next_proc   <= res.next_proc;
			report.all_done    <= res.all_done;
			report.last_of_run <= res.last_of_run;
		end
	end

endmodule

/* rtl/core/multilevel_feedback_queue_scheduler.sv */
// Multilevel feedback queue scheduler with periodic priority boost.
// Depends on mfq_pkg, mfq_ifs, mfq_ram, mfq_ptrs and mfq_outreg.
//
// Use: the slice channel takes one request at a time. kind 0 restarts the
// run, loading process ids 1..num_procs into the top level; kind 1 serves
// the head of the highest non-empty level with the given command. Each
// request yields one or more results on the report channel; the last one
// carries last_of_run. Configuration writes go over the cfg channel, which
// is always ready, and are meant for times when no request is in flight.
// Sequence: a slice request pops the head of its level, then looks up the
// next process before its first result goes out. A boost adds an init
// step, a scan of each lower level and a scan and a move per moved
// process, and each moved process then reports in turn. A start request
// loads one id per step, then looks up the next process. The store has
// one write port and one read port with registered read data. A new
// request is taken as soon as the last result waits in the output register.
// Reset empties every level, clears the slice counter and restores the
// register defaults (3 levels, 4 processes, boost every 8 slices); the
// store itself needs no clearing since only written entries are read.
// A stalled report sink holds the sequencer in its emit states.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; (
	input logic clk,
	input logic arst_n,
	mfq_cfg_if.sink      cfg,
	mfq_slice_if.sink    slice,
	mfq_report_if.source report
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_POP,
		S_BINIT,
		S_BSCAN,
		S_BMOVE,
		S_FIND,
		S_FWAIT,
		S_EMIT,
		S_BEMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [NQ_W-1:0] num_queues_q;
	logic [NP_W-1:0] num_procs_q;
	logic [BP_W-1:0] boost_period_q;

	// Sequencer registers.
	logic [LVL_W-1:0]   serve_lvl_q;
	logic               cmd_q;
	logic               last_q;
	logic [NP_W-1:0]    load_id_q;
	logic [LVL_W-1:0]   lv_q;
	logic [CNT_W-1:0]   moved_q;
	logic [CNT_W-1:0]   remain_q;
	logic [POS_W-1:0]   bstart_q;
	logic [POS_W-1:0]   bidx_q;
	ev_t                res_ev_q;
	logic               res_cmd_q;
	logic [ID_W-1:0]    res_id_q;
	logic [LEVEL_W-1:0] res_lvl_q;
	logic [ID_W-1:0]    nextp_q;
	logic               done_q;
	logic [BP_W-1:0]    slice_cnt_q;

	// Datapath wiring.
	logic [NQ_W-1:0]  nq;
	logic [NQ_W-1:0]  nq_m1;
	logic [NQ_W-1:0]  nq_m2;
	logic [LVL_W-1:0] top;
	logic [NP_W-1:0]  np;
	logic [LVL_W-1:0] new_lvl;
	logic [BP_W-1:0]  cnt_inc;
	logic             slice_acc;

	ptr_op_t          op;
	ptr_stat_t        st;
	logic [LVL_W-1:0] sel_q;
	logic [ID_W-1:0]  push_id;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ID_W-1:0]   rd_data;
	logic              wr_en;

	logic out_load;
	logic out_free;
	res_t out_res;

	assign nq      = levels_used(num_queues_q);
	assign nq_m1   = nq - NQ_W'(1);
	assign nq_m2   = nq - NQ_W'(2);
	assign top     = nq_m1[LVL_W-1:0];
	assign np      = procs_used(num_procs_q);
	assign cnt_inc = slice_cnt_q + BP_W'(1);

	// A demote command lowers the served process by one level, the bottom
	// level being the floor.
	assign new_lvl = (cmd_q && (serve_lvl_q != '0)) ? serve_lvl_q - LVL_W'(1) : serve_lvl_q;

	assign cfg.ready   = 1'b1;
	assign slice.ready = (state_q == S_IDLE);
	assign slice_acc   = slice.valid && slice.ready;

	// Configuration writes; indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_queues_q   <= NQ_W'(3);
			num_procs_q    <= NP_W'(4);
			boost_period_q <= BP_W'(8);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_NUM_QUEUES:   num_queues_q   <= cfg.data[NQ_W-1:0];
				REG_NUM_PROCS:    num_procs_q    <= cfg.data[NP_W-1:0];
				REG_BOOST_PERIOD: boost_period_q <= cfg.data[BP_W-1:0];
				default: ;
			endcase
		end
	end

	// Memory and pointer control for each sequencer state. No state reads
	// and writes the store in the same cycle, and every read result is
	// consumed in the state that follows, so accesses never overlap.
	always_comb begin
		op       = '0;
		sel_q    = st.busy_q;
		push_id  = '0;
		rd_en    = 1'b0;
		rd_addr  = {st.busy_q, st.sel_head};
		out_load = 1'b0;
		out_res  = '0;
		case (state_q)
			S_IDLE: begin
				if (slice_acc) begin
					if (!slice.kind) begin
						op.clr_all = 1'b1;
					end else if (st.busy_vld) begin
						rd_en = 1'b1;
					end
				end
			end
			S_LOAD: begin
				op.push_en = 1'b1;
				op.push_q  = top;
				push_id    = load_id_q;
			end
			S_POP: begin
				sel_q     = serve_lvl_q;
				op.pop_en = 1'b1;
				op.pop_q  = serve_lvl_q;
				if (!last_q) begin
					op.push_en = 1'b1;
					op.push_q  = new_lvl;
					push_id    = rd_data;
				end
			end
			S_BINIT: begin
				sel_q = top;
			end
			S_BSCAN: begin
				sel_q   = lv_q;
				rd_addr = {lv_q, st.sel_head};
				rd_en   = (st.sel_count != '0);
			end
			S_BMOVE: begin
				sel_q      = lv_q;
				op.pop_en  = 1'b1;
				op.pop_q   = lv_q;
				op.push_en = 1'b1;
				op.push_q  = top;
				push_id    = rd_data;
			end
			S_FIND: begin
				rd_en = st.busy_vld;
			end
			S_FWAIT: begin
			end
			S_EMIT: begin
				rd_addr = {top, bstart_q};
				if (out_free) begin
					out_load            = 1'b1;
					out_res.event_res   = res_ev_q;
					out_res.cmd_echo    = res_cmd_q;
					out_res.proc_id     = res_id_q;
					out_res.level       = res_lvl_q;
					out_res.next_proc   = nextp_q;
					out_res.all_done    = done_q;
					out_res.last_of_run = (moved_q == '0);
					rd_en               = (moved_q != '0);
				end
			end
			S_BEMIT: begin
				// Boosted processes sit at the tail of the top level in
				// the order they moved, so they are read back from there.
				rd_addr = {top, bidx_q + POS_W'(1)};
				if (out_free) begin
					out_load            = 1'b1;
					out_res.event_res   = EV_BOOST;
					out_res.cmd_echo    = 1'b0;
					out_res.proc_id     = rd_data;
					out_res.level       = nq;
					out_res.next_proc   = nextp_q;
					out_res.all_done    = done_q;
					out_res.last_of_run = (remain_q == CNT_W'(1));
					rd_en               = (remain_q != CNT_W'(1));
				end
			end
			default: ;
		endcase
	end

	assign wr_en = op.push_en && st.push_ok;

	mfq_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({op.push_q, st.push_tail}),
		.wr_data (push_id),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mfq_ptrs u_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.sel_q  (sel_q),
		.nq     (nq),
		.st     (st)
	);

	mfq_outreg u_outreg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.res    (out_res),
		.free   (out_free),
		.report (report)
	);

	// Sequencer: state and its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			serve_lvl_q <= '0;
			cmd_q       <= 1'b0;
			last_q      <= 1'b0;
			load_id_q   <= '0;
			lv_q        <= '0;
			moved_q     <= '0;
			remain_q    <= '0;
			bstart_q    <= '0;
			bidx_q      <= '0;
			res_ev_q    <= EV_IDLE;
			res_cmd_q   <= 1'b0;
			res_id_q    <= '0;
			res_lvl_q   <= '0;
			nextp_q     <= '0;
			done_q      <= 1'b0;
			slice_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (slice_acc) begin
						moved_q   <= '0;
						cmd_q     <= slice.demote_cmd;
						last_q    <= slice.last_cmd;
						res_ev_q  <= EV_IDLE;
						res_cmd_q <= 1'b0;
						res_id_q  <= '0;
						res_lvl_q <= '0;
						if (!slice.kind) begin
							slice_cnt_q <= '0;
							load_id_q   <= NP_W'(1);
							state_q     <= (np == '0) ? S_FIND : S_LOAD;
						end else if (st.busy_vld) begin
							serve_lvl_q <= st.busy_q;
							state_q     <= S_POP;
						end else begin
							// Nothing to run: the slice counter stays put.
							state_q <= S_FIND;
						end
					end
				end
				S_LOAD: begin
					load_id_q <= load_id_q + NP_W'(1);
					if (load_id_q == np) begin
						state_q <= S_FIND;
					end
				end
				S_POP: begin
					res_cmd_q <= cmd_q;
					res_id_q  <= rd_data;
					if (last_q) begin
						res_ev_q  <= EV_EXIT;
						res_lvl_q <= '0;
					end else begin
						res_ev_q  <= EV_RAN;
						res_lvl_q <= LEVEL_W'(new_lvl) + LEVEL_W'(1);
					end
					// Exits count as served slices too.
					if (cnt_inc == boost_period_q) begin
						slice_cnt_q <= '0;
						state_q     <= S_BINIT;
					end else begin
						slice_cnt_q <= cnt_inc;
						state_q     <= S_FIND;
					end
				end
				S_BINIT: begin
					bstart_q <= st.sel_tail;
					lv_q     <= nq_m2[LVL_W-1:0];
					state_q  <= (nq == NQ_W'(1)) ? S_FIND : S_BSCAN;
				end
				S_BSCAN: begin
					if (st.sel_count != '0) begin
						state_q <= S_BMOVE;
					end else if (lv_q == '0) begin
						state_q <= S_FIND;
					end else begin
						lv_q <= lv_q - LVL_W'(1);
					end
				end
				S_BMOVE: begin
					moved_q <= moved_q + CNT_W'(1);
					state_q <= S_BSCAN;
				end
				S_FIND: begin
					if (st.busy_vld) begin
						state_q <= S_FWAIT;
					end else begin
						nextp_q <= '0;
						done_q  <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_FWAIT: begin
					nextp_q <= rd_data;
					done_q  <= 1'b0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						bidx_q   <= bstart_q;
						remain_q <= moved_q;
						state_q  <= (moved_q == '0) ? S_IDLE : S_BEMIT;
					end
				end
				S_BEMIT: begin
					if (out_free) begin
						bidx_q   <= bidx_q + POS_W'(1);
						remain_q <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// At most MAX_PROCS processes exist, so a push never finds its level full.
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		op.push_en |-> st.push_ok)
		else $error("push into a full level");

	// Boost pops only ever take from a non-empty level.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(op.pop_en && (state_q == S_BMOVE)) |-> (st.sel_count != '0))
		else $error("boost pop from an empty level");

	// An empty scheduler names no next process.
	a_done_no_next: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.all_done) |-> (report.next_proc == '0))
		else $error("next process reported while all levels are empty");

	// A boost move only happens after a scan found work at that level.
	a_move_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BMOVE) |-> ($past(state_q) == S_BSCAN))
		else $error("boost move without a preceding scan");

endmodule
